// ===== rtl/core/ntc_pkg.sv =====
// ----------------------------------------------------------------------------
// ntc_pkg: shared types, constants and helpers
// Character codes, the token passed between the neighbor stage and the
// bracket filter, and the byte classification functions.
// ----------------------------------------------------------------------------
package ntc_pkg;

  // Default held-whitespace capacity and the per-transaction result limit
  parameter int NTC_PENDING_DEPTH = 16;
  parameter int NTC_MAX_RESULTS   = 20;
  parameter int NTC_SCW           = $clog2(NTC_MAX_RESULTS + 1);

  // Character codes
  localparam logic [7:0] CH_O_LOWER = 8'h6F;  // o
  localparam logic [7:0] CH_O_UPPER = 8'h4F;  // O
  localparam logic [7:0] CH_UNDER   = 8'h5F;  // _
  localparam logic [7:0] CH_DASH    = 8'h2D;  // -
  localparam logic [7:0] CH_ZERO    = 8'h30;  // 0
  localparam logic [7:0] CH_COLON   = 8'h3A;  // :
  localparam logic [7:0] CH_SEMI    = 8'h3B;  // ;
  localparam logic [7:0] CH_LPAREN  = 8'h28;  // (
  localparam logic [7:0] CH_RPAREN  = 8'h29;  // )
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  // Up to two mapped bytes per input transaction, plus the line end flag
  typedef struct packed {
    logic       b1_keep;   // mapped held byte survives
    logic [7:0] b1;
    logic       b2_keep;   // mapped final byte survives (line end only)
    logic [7:0] b2;
    logic       line_end;
  } ntc_tok_t;

  typedef struct packed {
    logic       keep;
    logic [7:0] value;
  } ntc_map_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic likely_letter(input logic [7:0] c);
    return is_letter(c) && (c != CH_O_LOWER) && (c != CH_O_UPPER);
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Neighbor-based mapping of one byte
  function automatic ntc_map_t map_byte(
    input logic [7:0] c,
    input logic       has_prev,
    input logic [7:0] prev,
    input logic       has_next,
    input logic [7:0] next,
    input logic       excl
  );
    ntc_map_t r;
    r.keep  = 1'b1;
    r.value = c;
    if (((c == CH_O_LOWER) || (c == CH_O_UPPER)) &&
        (!has_prev || !likely_letter(prev)) &&
        (!has_next || !likely_letter(next))) begin
      r.value = CH_ZERO;
    end else if (c == CH_UNDER) begin
      r.value = CH_DASH;
    end else if (excl && (is_letter(c) || (c == CH_COLON) || (c == CH_SEMI))) begin
      r.keep = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/ntc_tokenizer.sv =====
// ----------------------------------------------------------------------------
// ntc_tokenizer: neighbor stage
// Holds one byte back so each byte sees its original neighbors, applies the
// o/O, underscore and tag-exclusion rules, and registers a token.
// ----------------------------------------------------------------------------
module ntc_tokenizer
  import ntc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_byte,
  input  logic       line_last,
  output logic       tok_valid,
  input  logic       tok_ready,
  output ntc_tok_t   tok
);

  logic       exclude_tags;
  logic [7:0] prev_orig;
  logic       prev_present;
  logic [7:0] delayed_byte;
  logic       delayed_valid;

  logic       accept;
  ntc_map_t   map1;
  ntc_map_t   map2;
  logic       p2_present;
  logic [7:0] p2_byte;
  ntc_tok_t   tok_next;

  assign in_ready = !tok_valid || tok_ready;
  assign accept   = in_valid && in_ready;

  // Held byte sees the new byte as its right neighbor
  assign map1 = map_byte(delayed_byte, prev_present, prev_orig, 1'b1, text_byte,
                         exclude_tags);

  // Final byte of a line: left neighbor is the held byte if there is one
  assign p2_present = delayed_valid || prev_present;
  assign p2_byte    = delayed_valid ? delayed_byte : prev_orig;
  assign map2 = map_byte(text_byte, p2_present, p2_byte, 1'b0, 8'h00, exclude_tags);

  always_comb begin
    tok_next.b1_keep  = delayed_valid && map1.keep;
    tok_next.b1       = map1.value;
    tok_next.b2_keep  = line_last && map2.keep;
    tok_next.b2       = map2.value;
    tok_next.line_end = line_last;
  end

  // Control state, config register and neighbor history
  always_ff @(posedge clk) begin
    if (rst) begin
      exclude_tags  <= 1'b1;
      tok_valid     <= 1'b0;
      prev_orig     <= '0;
      prev_present  <= 1'b0;
      delayed_byte  <= '0;
      delayed_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        exclude_tags <= cfg_wdata;
      end
      if (accept) begin
        tok_valid <= 1'b1;
        if (line_last) begin
          prev_orig     <= '0;
          prev_present  <= 1'b0;
          delayed_byte  <= '0;
          delayed_valid <= 1'b0;
        end else begin
          delayed_byte  <= text_byte;
          delayed_valid <= 1'b1;
          if (delayed_valid) begin
            prev_orig    <= delayed_byte;
            prev_present <= 1'b1;
          end
        end
      end else if (tok_ready) begin
        tok_valid <= 1'b0;
      end
    end
  end

  // Token payload
  always_ff @(posedge clk) begin
    if (accept) begin
      tok <= tok_next;
    end
  end

  // History is only present behind a held byte
  a_prev_needs_held: assert property (@(posedge clk) disable iff (rst)
    prev_present |-> delayed_valid)
    else $error("left-neighbor history without a held byte");

  // A line end clears the held byte
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && line_last) |=> !delayed_valid && !prev_present)
    else $error("line state not cleared after final byte");

  // Only a line-end token carries a final byte
  a_b2_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (tok_valid && !tok.line_end) |-> !tok.b2_keep)
    else $error("final byte in a token without line end");

endmodule

// ===== rtl/core/ntc_bracket_filter.sv =====
// ----------------------------------------------------------------------------
// ntc_bracket_filter: empty bracket removal and result sequencing
// Holds an open bracket and the whitespace after it, drops an empty pair,
// flushes held bytes one per cycle unless stalled, tags each line's last result.
// ----------------------------------------------------------------------------
module ntc_bracket_filter
  import ntc_pkg::*;
#(
  parameter int PENDING_DEPTH = NTC_PENDING_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       tok_valid,
  output logic       tok_ready,
  input  ntc_tok_t   tok,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       out_last
);

  localparam int CW = $clog2(PENDING_DEPTH + 1);
  localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  typedef enum logic [2:0] {
    P_B1, P_B2, P_END, P_FLUSH_OPEN, P_FLUSH_WS, P_TAIL, P_FINAL
  } phase_t;

  typedef enum logic [2:0] {
    ACT_EMIT, ACT_OPEN, ACT_CLOSE, ACT_STORE, ACT_FLUSH
  } act_t;

  // What one byte does to the bracket state
  function automatic act_t byte_action(input logic [7:0] b, input logic is_open,
                                       input logic is_full);
    act_t a;
    if (is_open) begin
      if (b == CH_RPAREN) begin
        a = ACT_CLOSE;
      end else if (is_ws(b)) begin
        a = is_full ? ACT_FLUSH : ACT_STORE;
      end else begin
        a = ACT_FLUSH;
      end
    end else begin
      a = (b == CH_LPAREN) ? ACT_OPEN : ACT_EMIT;
    end
    return a;
  endfunction

  // State
  phase_t             phase, phase_next;
  phase_t             ret_phase, ret_next;
  logic               bracket_open, open_next;
  logic [CW-1:0]      pend_count, cnt_next;
  logic [PW-1:0]      fptr, fptr_next;
  logic [7:0]         tail_byte, tail_byte_next;
  logic               tail_has, tail_has_next;
  logic [7:0]         stash_byte;
  logic               stash_valid;
  logic [NTC_SCW-1:0] scount;

  logic [7:0]         pend_mem [PENDING_DEPTH];
  logic [7:0]         rd_data;

  // Per-cycle control
  logic               en;
  logic               emit, emit_ok, final_en, wr_en, do_act, flush_done;
  logic [7:0]         emit_data, act_data;
  logic               act_open, act_full;
  phase_t             adv;
  act_t               action;

  // Output register load
  logic               out_load;
  logic [7:0]         load_byte;
  logic               load_has, load_last;

  assign en       = tok_valid && (!out_valid || out_ready);
  assign act_full = (pend_count == CW'(PENDING_DEPTH));

  // Sequencer: one step of the current token per cycle unless the output stalls
  always_comb begin
    phase_next     = phase;
    ret_next       = ret_phase;
    open_next      = bracket_open;
    cnt_next       = pend_count;
    fptr_next      = fptr;
    tail_byte_next = tail_byte;
    tail_has_next  = tail_has;
    emit           = 1'b0;
    emit_data      = '0;
    final_en       = 1'b0;
    wr_en          = 1'b0;
    do_act         = 1'b0;
    flush_done     = 1'b0;
    act_data       = tok.b1;
    act_open       = bracket_open;
    adv            = phase;
    action         = ACT_EMIT;
    if (en) begin
      unique case (phase)
        P_B1: begin
          adv      = tok.line_end ? P_B2 : P_B1;
          act_data = tok.b1;
          do_act   = tok.b1_keep;
          if (!tok.b1_keep) phase_next = adv;
        end
        P_B2: begin
          adv      = P_END;
          act_data = tok.b2;
          do_act   = tok.b2_keep;
          if (!tok.b2_keep) phase_next = adv;
        end
        P_END: begin
          if (bracket_open) begin
            phase_next    = P_FLUSH_OPEN;
            tail_has_next = 1'b0;
            ret_next      = P_FINAL;
          end else begin
            phase_next = P_FINAL;
          end
        end
        P_FLUSH_OPEN: begin
          emit      = 1'b1;
          emit_data = CH_LPAREN;
          if (pend_count == '0) begin
            flush_done = 1'b1;
          end else begin
            phase_next = P_FLUSH_WS;
            fptr_next  = '0;
          end
        end
        P_FLUSH_WS: begin
          emit      = 1'b1;
          emit_data = rd_data;
          if (CW'(fptr) + CW'(1) == pend_count) begin
            flush_done = 1'b1;
          end else begin
            fptr_next = fptr + PW'(1);
          end
        end
        P_TAIL: begin
          adv      = ret_phase;
          act_data = tail_byte;
          act_open = 1'b0;
          do_act   = 1'b1;
        end
        P_FINAL: begin
          final_en   = 1'b1;
          phase_next = P_B1;
        end
        default: phase_next = P_B1;
      endcase

      // End of a flush: bracket no longer open
      if (flush_done) begin
        open_next  = 1'b0;
        cnt_next   = '0;
        phase_next = tail_has ? P_TAIL : ret_phase;
      end

      // Apply the bracket action of the selected byte
      if (do_act) begin
        action     = byte_action(act_data, act_open, act_full);
        phase_next = adv;
        case (action)
          ACT_EMIT: begin
            emit      = 1'b1;
            emit_data = act_data;
          end
          ACT_OPEN: begin
            open_next = 1'b1;
            cnt_next  = '0;
          end
          ACT_CLOSE: begin
            open_next = 1'b0;
            cnt_next  = '0;
          end
          ACT_STORE: begin
            wr_en    = 1'b1;
            cnt_next = pend_count + CW'(1);
          end
          ACT_FLUSH: begin
            phase_next     = P_FLUSH_OPEN;
            tail_byte_next = act_data;
            tail_has_next  = 1'b1;
            ret_next       = adv;
          end
          default: ;
        endcase
      end
    end
  end

  // Token is done when the sequencer returns to its first phase
  assign tok_ready = en && (phase_next == P_B1);

  // Results beyond the per-transaction limit are dropped
  assign emit_ok = emit && (scount != NTC_SCW'(NTC_MAX_RESULTS));

  // Result routing: a line's results pass through the stash so the last
  // kept one can carry the line end flag
  always_comb begin
    out_load  = 1'b0;
    load_byte = '0;
    load_has  = 1'b1;
    load_last = 1'b0;
    if (final_en) begin
      out_load  = 1'b1;
      load_byte = stash_valid ? stash_byte : 8'h00;
      load_has  = stash_valid;
      load_last = 1'b1;
    end else if (emit_ok) begin
      if (tok.line_end) begin
        out_load  = stash_valid;
        load_byte = stash_byte;
      end else begin
        out_load  = 1'b1;
        load_byte = emit_data;
      end
    end
  end

  // State and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= P_B1;
      ret_phase    <= P_B1;
      bracket_open <= 1'b0;
      pend_count   <= '0;
      fptr         <= '0;
      tail_has     <= 1'b0;
      stash_valid  <= 1'b0;
      scount       <= '0;
      out_valid    <= 1'b0;
    end else begin
      phase        <= phase_next;
      ret_phase    <= ret_next;
      bracket_open <= open_next;
      pend_count   <= cnt_next;
      fptr         <= fptr_next;
      tail_has     <= tail_has_next;
      tail_byte    <= tail_byte_next;
      if (tok_ready) begin
        scount <= '0;
      end else if (emit_ok) begin
        scount <= scount + NTC_SCW'(1);
      end
      if (final_en) begin
        stash_valid <= 1'b0;
      end else if (emit_ok && tok.line_end) begin
        stash_valid <= 1'b1;
        stash_byte  <= emit_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
        out_byte  <= load_byte;
        has_byte  <= load_has;
        out_last  <= load_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Held whitespace buffer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pend_mem[pend_count[PW-1:0]] <= act_data;
    end
    rd_data <= pend_mem[fptr_next];
  end

  // An end marker always closes a line
  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_byte) |-> out_last)
    else $error("end marker without line end flag");

  // Whitespace is held only behind an open bracket
  a_count_needs_open: assert property (@(posedge clk) disable iff (rst)
    !bracket_open |-> (pend_count == '0))
    else $error("held whitespace without open bracket");

  // Stash is used only while a line-end token is in work
  a_stash_in_end: assert property (@(posedge clk) disable iff (rst)
    stash_valid |-> (tok_valid && tok.line_end))
    else $error("stashed result outside line end");

  // Buffer and result counters stay in range
  a_counts_range: assert property (@(posedge clk) disable iff (rst)
    (pend_count <= CW'(PENDING_DEPTH)) &&
    (scount <= NTC_SCW'(NTC_MAX_RESULTS)))
    else $error("counter out of range");

endmodule

// ===== rtl/core/numeric_text_cleanup_core.sv =====
// Latency: a non-final byte is held until the next byte arrives; its result
//   then passes through the token register and the filter's output register.
// Throughput: 1 byte per cycle unless the output stalls; a final byte steps
//   through filter phases B1, B2, END and FINAL, and a flush emits the held
//   bracket, its held bytes and then any byte that ended the bracket, in turn.
// Reset (rst, synchronous): control state cleared, exclude_tags set to 1; the
//   whitespace buffer is not cleared.
// ----------------------------------------------------------------------------
// numeric_text_cleanup_core: top level of the OCR number-line cleaner
// Neighbor stage feeding the empty-bracket filter and result sequencer.
// ----------------------------------------------------------------------------
module numeric_text_cleanup_core
  import ntc_pkg::*;
#(
  parameter int PENDING_DEPTH = NTC_PENDING_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_byte,
  input  logic       line_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       out_last
);

  logic     tok_valid;
  logic     tok_ready;
  ntc_tok_t tok;

  // Neighbor rules and tag exclusion
  ntc_tokenizer u_tokenizer (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .text_byte (text_byte),
    .line_last (line_last),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok)
  );

  // Empty bracket removal and output sequencing
  ntc_bracket_filter #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_filter (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .has_byte  (has_byte),
    .out_last  (out_last)
  );

endmodule
